[design/dnse_pkg.sv]
// Shared types and constants of the host name to wire-format encoder.
`default_nettype none

package dnse_pkg;

   // Width of a label character count; covers the largest allowed label.
   localparam int LABEL_CNT_W = 6;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // Error codes carried on results
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_NAME  = 2'd1;
   localparam logic [1:0] ERR_LABEL = 2'd2;

   // Command kinds passed from the front to the back
   typedef enum logic {
      CMD_SINGLE,   // one zero byte, last of its item, with an error code
      CMD_FLUSH     // length byte then the buffered label characters
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [1:0]             err;        // single: error code
      logic [LABEL_CNT_W-1:0] count;      // flush: label length
      logic                   bank;       // flush: label buffer bank
      logic                   pre_zero;   // flush: emit a zero length byte first
      logic                   zf_final;   // flush: last byte carries the terminator
   } cmd_type;

   // Back reports a finished label so the front may reuse its bank
   typedef struct packed {
      logic valid;
      logic bank;
   } flush_done_type;

endpackage

`default_nettype wire

[design/dnse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dnse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[design/dnse_cmd_fifo.sv]
// Two-entry command queue between the front and the back.
`default_nettype none

module dnse_cmd_fifo
   import dnse_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         empty
);

   localparam int DEPTH = 2;

   cmd_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

endmodule

`default_nettype wire

[design/dnse_front.sv]
// Front end: accepts characters, tracks label and name state, buffers label bytes.
`default_nettype none

module dnse_front
   import dnse_pkg::*;
#(
   parameter int MAX_LABEL = 63,
   parameter int MAX_NAME  = 255
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   req_tlast,
   input  wire logic                   q_full,
   output logic                        q_push,
   output cmd_type                     q_cmd,
   input  wire flush_done_type         flush_done,
   output logic                        wr_en,
   output logic                        wr_bank,
   output logic [LABEL_CNT_W-1:0]      wr_index,
   output logic [7:0]                  wr_data
);

   localparam int NAME_W = $clog2(MAX_NAME);

   logic [LABEL_CNT_W-1:0] label_count_ff, label_count_in;
   logic [NAME_W-1:0]      name_length_ff, name_length_in;
   logic [1:0]             error_ff, error_in;
   logic                   only_dot_ff, only_dot_in;
   logic                   bank_ff, bank_in;
   logic [1:0]             busy_ff, busy_in;
   logic                   accept;
   logic                   is_dot;

   // Hold off while the queue is full or the fill bank is still being replayed
   assign req_tready = !q_full && !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign is_dot     = (req_tdata == DOT_CHAR);
   assign wr_bank    = bank_ff;
   assign wr_index   = label_count_ff;
   assign wr_data    = req_tdata;

   // Classify the transfer and build the command for the back
   always_comb begin
      label_count_in = label_count_ff;
      name_length_in = name_length_ff;
      error_in       = error_ff;
      only_dot_in    = only_dot_ff;
      bank_in        = bank_ff;
      busy_in        = busy_ff;
      q_push         = 1'b0;
      q_cmd          = '0;
      wr_en          = 1'b0;

      if (flush_done.valid) begin
         busy_in[flush_done.bank] = 1'b0;
      end

      if (accept) begin
         if (req_tlast) begin
            q_push = 1'b1;
            if (error_ff != ERR_NONE) begin
               q_cmd.kind = CMD_SINGLE;
               q_cmd.err  = error_ff;
            end else if (label_count_ff == '0) begin
               q_cmd.kind = CMD_SINGLE;
               q_cmd.err  = ERR_NONE;
            end else begin
               q_cmd.kind     = CMD_FLUSH;
               q_cmd.count    = label_count_ff;
               q_cmd.bank     = bank_ff;
               q_cmd.zf_final = 1'b1;
               bank_in          = ~bank_ff;
               busy_in[bank_ff] = 1'b1;
            end
            label_count_in = '0;
            name_length_in = '0;
            error_in       = ERR_NONE;
            only_dot_in    = 1'b0;
         end else if (error_ff == ERR_NONE) begin
            if (name_length_ff >= NAME_W'(MAX_NAME - 1)) begin
               error_in    = ERR_NAME;
               only_dot_in = 1'b0;
            end else if (!is_dot && label_count_ff >= LABEL_CNT_W'(MAX_LABEL)) begin
               error_in    = ERR_LABEL;
               only_dot_in = 1'b0;
            end else if (is_dot && name_length_ff == '0) begin
               name_length_in = NAME_W'(1);
               only_dot_in    = 1'b1;
            end else begin
               name_length_in = name_length_ff + NAME_W'(1);
               only_dot_in    = 1'b0;
               if (is_dot) begin
                  q_push           = 1'b1;
                  q_cmd.kind       = CMD_FLUSH;
                  q_cmd.count      = label_count_ff;
                  q_cmd.bank       = bank_ff;
                  q_cmd.pre_zero   = only_dot_ff;
                  bank_in          = ~bank_ff;
                  busy_in[bank_ff] = 1'b1;
                  label_count_in   = '0;
               end else begin
                  wr_en          = 1'b1;
                  label_count_in = label_count_ff + LABEL_CNT_W'(1);
                  if (only_dot_ff) begin
                     q_push     = 1'b1;
                     q_cmd.kind = CMD_SINGLE;
                     q_cmd.err  = ERR_NONE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff <= '0;
         name_length_ff <= '0;
         error_ff       <= ERR_NONE;
         only_dot_ff    <= 1'b0;
         bank_ff        <= 1'b0;
         busy_ff        <= '0;
      end else begin
         label_count_ff <= label_count_in;
         name_length_ff <= name_length_in;
         error_ff       <= error_in;
         only_dot_ff    <= only_dot_in;
         bank_ff        <= bank_in;
         busy_ff        <= busy_in;
      end
   end

   a_done_of_busy_bank: assert property (@(posedge clock) disable iff (reset)
      flush_done.valid |-> busy_ff[flush_done.bank])
      else $error("label replay finished on a bank that was not in use");

   a_end_clears_name: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (label_count_ff == '0 && name_length_ff == '0
                                 && error_ff == ERR_NONE && !only_dot_ff))
      else $error("name state not cleared after end of name");

endmodule

`default_nettype wire

[design/dnse_back.sv]
// Back end: turns queued commands into wire bytes, replaying labels from the buffer.
`default_nettype none

module dnse_back
   import dnse_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire cmd_type                q_cmd,
   output logic                        q_pop,
   output logic                        rd_bank,
   output logic [LABEL_CNT_W-1:0]      rd_index,
   input  wire logic [7:0]             rd_data,
   output flush_done_type              flush_done,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // out_byte
   output logic                        rsp_tlast,   // run_last
   output logic [2:0]                  rsp_tuser    // [0] zero_follows, [2:1] error_code
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_PREZ,
      ST_LEN,
      ST_FETCH,
      ST_SEND
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [LABEL_CNT_W-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   zf_ff, zf_in;
   logic                   rl_ff, rl_in;
   logic [1:0]             err_ff, err_in;
   logic                   done_ff, done_in;
   logic                   done_bank_ff, done_bank_in;
   logic                   out_free;
   logic                   last_char;

   assign out_free  = !valid_ff || rsp_tready;
   assign last_char = (idx_ff == cmd_ff.count - LABEL_CNT_W'(1));
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rd_bank   = cmd_ff.bank;
   assign rd_index  = idx_ff;

   assign rsp_tvalid       = valid_ff;
   assign rsp_tdata        = byte_ff;
   assign rsp_tlast        = rl_ff;
   assign rsp_tuser        = {err_ff, zf_ff};
   assign flush_done.valid = done_ff;
   assign flush_done.bank  = done_bank_ff;

   // Sequence one command at a time into the output register
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff && !rsp_tready;
      byte_in      = byte_ff;
      zf_in        = zf_ff;
      rl_in        = rl_ff;
      err_in       = err_ff;
      done_in      = 1'b0;
      done_bank_in = done_bank_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               cmd_in = q_cmd;
               if (q_cmd.kind == CMD_SINGLE) begin
                  state_in = ST_SINGLE;
               end else if (q_cmd.pre_zero) begin
                  state_in = ST_PREZ;
               end else begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = 8'd0;
               zf_in    = 1'b0;
               rl_in    = 1'b1;
               err_in   = cmd_ff.err;
               state_in = ST_IDLE;
            end
         end
         ST_PREZ: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = 8'd0;
               zf_in    = 1'b0;
               rl_in    = 1'b0;
               err_in   = ERR_NONE;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = 8'(cmd_ff.count);
               zf_in    = 1'b0;
               rl_in    = (cmd_ff.count == '0);
               err_in   = ERR_NONE;
               idx_in   = '0;
               if (cmd_ff.count == '0) begin
                  done_in      = 1'b1;
                  done_bank_in = cmd_ff.bank;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // read address settles this cycle, data is valid in the next
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = rd_data;
               zf_in    = last_char && cmd_ff.zf_final;
               rl_in    = last_char;
               err_in   = ERR_NONE;
               if (last_char) begin
                  done_in      = 1'b1;
                  done_bank_in = cmd_ff.bank;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + LABEL_CNT_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= 1'b0;
         done_ff      <= 1'b0;
         done_bank_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         done_ff      <= done_in;
         done_bank_ff <= done_bank_in;
      end
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      zf_ff   <= zf_in;
      rl_ff   <= rl_in;
      err_ff  <= err_in;
   end

   a_zero_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && zf_ff) |-> rl_ff)
      else $error("terminator flagged on a byte that is not last of its transfer run");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != ST_IDLE)
      else $error("command popped but back stayed idle");

endmodule

`default_nettype wire

[design/dns_name_to_wire_encoder.sv]
// Top level of the host name to wire-format encoder.
//
// Usage: characters of a dotted host name arrive on the req_ channel, one per
// transfer, in req_tdata; the name closes with a transfer that has req_tlast
// high (its data is ignored). Wire bytes leave on the rsp_ channel: a label
// length byte, then the label characters, with rsp_tlast on the last byte
// caused by one request. A name that ends inside a label carries zero_follows in
// rsp_tuser[0] on its final byte for the terminating zero; errors appear in
// rsp_tuser[2:1]. A label character gives no output until its dot or end; the
// first byte caused by that transfer then passes the command queue, the back's
// command register and the output register. Throughput: while req_tready is
// high the front takes one character per cycle into a two-bank label buffer;
// the back takes each command from the queue in its idle state, then emits a
// single byte or a length byte, then each label byte through a fetch state and
// a send state, following the fetch-then-send use of the buffer read port. A new
// label may fill while the previous one replays; a third waits for the older bank.
// Reset clears all name state and the command queue; the label buffer needs
// no clearing. When rsp_tready is low the output register holds and the
// front keeps accepting until the queue or the buffer banks fill.

`default_nettype none

module dns_name_to_wire_encoder
   import dnse_pkg::*;
#(
   parameter int MAX_LABEL = 63,
   parameter int MAX_NAME  = 255
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // char_in
   input  wire logic       req_tlast,   // end_of_name
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte
   output logic            rsp_tlast,   // run_last
   output logic [2:0]      rsp_tuser    // [0] zero_follows, [2:1] error_code
);

   localparam int IDX_W  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam int ADDR_W = IDX_W + 1;

   logic                   q_push, q_full, q_pop, q_empty;
   cmd_type                push_cmd, head_cmd;
   flush_done_type         flush_done;
   logic                   wr_en, wr_bank, rd_bank;
   logic [LABEL_CNT_W-1:0] wr_index, rd_index;
   logic [7:0]             wr_data, rd_data;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;

   // Bank bit selects the label buffer half
   assign wr_addr = {wr_bank, wr_index[IDX_W-1:0]};
   assign rd_addr = {rd_bank, rd_index[IDX_W-1:0]};

   dnse_front #(
      .MAX_LABEL (MAX_LABEL),
      .MAX_NAME  (MAX_NAME)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .flush_done (flush_done),
      .wr_en      (wr_en),
      .wr_bank    (wr_bank),
      .wr_index   (wr_index),
      .wr_data    (wr_data)
   );

   dnse_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   dnse_ram #(
      .WIDTH (8),
      .DEPTH (2 ** ADDR_W)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dnse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rd_bank    (rd_bank),
      .rd_index   (rd_index),
      .rd_data    (rd_data),
      .flush_done (flush_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
